// ----- src/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: operation codes,
// controller states and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Width of one stored value.
  localparam int DATA_W = 32;

  // Value reported when there is nothing to report (all ones, that is -1).
  localparam logic [DATA_W-1:0] EMPTY_MARK = '1;

  // Operation codes carried by an input beat.
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } deq_op_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_DONE
  } deq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the input beat
    logic exec;  // carry out the operation and update the ring
    logic fill;  // take the new end value from the store read port
  } deq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_fill;  // a pop leaves elements, so the new end must be read
  } deq_sts_t;

endpackage

// ----- src/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// deq_ctrl
// Controller for the double-ended queue. Sequences one operation at a time
// through execute, an optional store read, and the result strobe.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  deq_sts_t sts,
  output deq_cmd_t cmd,
  output logic     busy,
  output logic     done
);

  deq_state_t state;
  deq_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      ST_IDLE, ST_DONE: begin
        // The result strobe cycle also takes a new beat.
        busy = 1'b0;
        done = (state == ST_DONE);
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_fill) begin
          state_next = ST_FILL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_FILL: begin
        cmd.fill   = 1'b1;
        state_next = ST_DONE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // Nothing is taken or reported while reset is held.
    if (rst) begin
      cmd  = '0;
      busy = 1'b1;
      done = 1'b0;
    end
  end

endmodule

// ----- src/deq_datapath.sv -----
// ----------------------------------------------------------------------------
// deq_datapath
// Ring store, head index, element count and cached end values of the
// double-ended queue. Pops return the cached end value; the value that
// becomes the new end is read from the store and taken in the following cycle.
// ----------------------------------------------------------------------------
module deq_datapath import deq_pkg::*; #(
  parameter  int DEPTH = 16,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  deq_cmd_t                 cmd,
  output deq_sts_t                 sts,
  input  logic [1:0]               op,
  input  logic signed [DATA_W-1:0] push_value,
  output logic signed [DATA_W-1:0] popped_value,
  output logic                     ok,
  output logic signed [DATA_W-1:0] first_value,
  output logic signed [DATA_W-1:0] last_value,
  output logic                     is_empty,
  output logic [CNT_W-1:0]         count
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = CNT_W + 1;

  // Captured beat.
  deq_op_t            op_q;
  logic [DATA_W-1:0]  val_q;

  // Ring state.
  logic [IDX_W-1:0]   front;
  logic [CNT_W-1:0]   elems;
  logic [DATA_W-1:0]  first_q;
  logic [DATA_W-1:0]  last_q;
  logic [DATA_W-1:0]  popped_q;
  logic               ok_q;

  // Store and its registered read data.
  logic [DATA_W-1:0]  mem [DEPTH];
  logic [DATA_W-1:0]  rd_data;

  logic               is_push;
  logic               is_full;
  logic               none_held;
  logic               success;
  logic [IDX_W-1:0]   front_inc;
  logic [IDX_W-1:0]   front_dec;
  logic [SUM_W-1:0]   sum_push;
  logic [SUM_W-1:0]   sum_pop;
  logic [IDX_W-1:0]   push_back_idx;
  logic [IDX_W-1:0]   pop_back_idx;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic               mem_we;
  logic               mem_re;

  // Operation decode and ring index arithmetic.
  always_comb begin
    is_push   = (op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK);
    is_full   = (elems == CNT_W'(DEPTH));
    none_held = (elems == '0);
    success   = is_push ? !is_full : !none_held;

    front_inc = (front == IDX_W'(DEPTH - 1)) ? '0 : front + 1'b1;
    front_dec = (front == '0) ? IDX_W'(DEPTH - 1) : front - 1'b1;

    // Slot past the back element, for a push at the back.
    sum_push      = SUM_W'(front) + SUM_W'(elems);
    push_back_idx = (sum_push >= SUM_W'(DEPTH)) ? IDX_W'(sum_push - SUM_W'(DEPTH))
                                                : IDX_W'(sum_push);

    // Slot that becomes the back after a pop at the back (two or more held).
    sum_pop      = SUM_W'(front) + SUM_W'(elems) - SUM_W'(2);
    pop_back_idx = (sum_pop >= SUM_W'(DEPTH)) ? IDX_W'(sum_pop - SUM_W'(DEPTH))
                                              : IDX_W'(sum_pop);

    wr_idx = (op_q == OP_PUSH_FRONT) ? front_dec : push_back_idx;
    rd_idx = (op_q == OP_POP_FRONT) ? front_inc : pop_back_idx;

    sts.need_fill = !is_push && (elems > CNT_W'(1));
    mem_we        = cmd.exec && is_push && success;
    mem_re        = cmd.exec && sts.need_fill;
  end

  // Ring store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= val_q;
    end
    if (mem_re) begin
      rd_data <= mem[rd_idx];
    end
  end

  // Head index and element count.
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      elems <= '0;
    end else if (cmd.exec && success) begin
      unique case (op_q)
        OP_PUSH_FRONT: begin
          front <= front_dec;
          elems <= elems + 1'b1;
        end
        OP_PUSH_BACK: begin
          elems <= elems + 1'b1;
        end
        OP_POP_FRONT: begin
          front <= front_inc;
          elems <= elems - 1'b1;
        end
        OP_POP_BACK: begin
          elems <= elems - 1'b1;
        end
        default: begin
          elems <= elems;
        end
      endcase
    end
  end

  // Beat capture, result registers and cached end values.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= deq_op_t'(op);
      val_q <= push_value;
    end
    if (cmd.exec) begin
      ok_q <= success;
      if (!is_push && success) begin
        popped_q <= (op_q == OP_POP_FRONT) ? first_q : last_q;
      end else begin
        popped_q <= EMPTY_MARK;
      end
      if (is_push && success) begin
        if (none_held) begin
          first_q <= val_q;
          last_q  <= val_q;
        end else if (op_q == OP_PUSH_FRONT) begin
          first_q <= val_q;
        end else begin
          last_q <= val_q;
        end
      end
    end
    if (cmd.fill) begin
      if (op_q == OP_POP_FRONT) begin
        first_q <= rd_data;
      end else begin
        last_q <= rd_data;
      end
    end
  end

  // Result view; the end values read as -1 while the queue is empty.
  assign popped_value = popped_q;
  assign ok           = ok_q;
  assign first_value  = none_held ? EMPTY_MARK : first_q;
  assign last_value   = none_held ? EMPTY_MARK : last_q;
  assign is_empty     = none_held;
  assign count        = elems;

endmodule

// ----- src/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values held in a ring store.
//
//   Channel  | Handshake             | Payload
//   ---------+-----------------------+-----------------------------------------
//   command  | start in, busy out    | op, push_value
//   result   | done out (one cycle)  | popped_value, ok, first_value,
//            |                       | last_value, is_empty, count
//
// A beat is taken at an edge with start high and busy low. Its result shows
// with done after the execute state for a push or a failed operation, and after
// the execute and fill states for a pop that leaves elements behind, which waits
// on the registered read port of the ring store. A new beat can be taken in the
// done cycle. Reset is synchronous and empties the queue; store contents are kept.
// The receiver cannot stall; each result holds until the next beat executes.
// ----------------------------------------------------------------------------
module double_ended_queue import deq_pkg::*; #(
  parameter  int DEPTH = 16,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               op,
  input  logic signed [DATA_W-1:0] push_value,
  output logic                     done,
  output logic signed [DATA_W-1:0] popped_value,
  output logic                     ok,
  output logic signed [DATA_W-1:0] first_value,
  output logic signed [DATA_W-1:0] last_value,
  output logic                     is_empty,
  output logic [CNT_W-1:0]         count
);

  deq_cmd_t cmd;
  deq_sts_t sts;

  // Operation sequencer.
  deq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Ring store and queue state.
  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .op           (op),
    .push_value   (push_value),
    .popped_value (popped_value),
    .ok           (ok),
    .first_value  (first_value),
    .last_value   (last_value),
    .is_empty     (is_empty),
    .count        (count)
  );

`ifndef SYNTHESIS
  // The element count never exceeds the ring size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (count <= CNT_W'(DEPTH)))
    else $error("count above ring size");

  // A failed operation removes nothing and reports the empty marker.
  a_fail_marker: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (popped_value == EMPTY_MARK))
    else $error("failed operation reported a popped value");

  // A taken beat makes the block busy in the following cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("block not busy after taking a beat");

  // The empty flag agrees with the element count.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with count");
`endif

endmodule

// ----- tb/double_ended_queue_tb.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the ring-buffer deque. A short table of directed
// beats covers the empty and full corners, the extreme values and a stored
// -1; a long random run follows, where the mix of pushes and pops drifts so
// that the queue fills and drains many times. Every result is compared field
// by field with a ring model in the bench, or a typed row's own expectation.
// ----------------------------------------------------------------------------
module double_ended_queue_tb import deq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = 16;
  localparam int RAND_BEATS = 1700;

  // One result beat as the block reports it.
  typedef struct {
    logic signed [DATA_W-1:0] popped;
    logic                     ok;
    logic signed [DATA_W-1:0] first_v;
    logic signed [DATA_W-1:0] last_v;
    logic                     empty_f;
    logic [4:0]               cnt;
  } deq_result_t;

  // One row of the directed table; typed rows carry their own expectation.
  typedef struct {
    deq_op_t                  op;
    logic signed [DATA_W-1:0] value;
    logic                     typed;
    deq_result_t              res;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               op = OP_PUSH_FRONT;
  logic signed [DATA_W-1:0] push_value = '0;
  logic                     done;
  logic signed [DATA_W-1:0] popped_value;
  logic                     ok;
  logic signed [DATA_W-1:0] first_value;
  logic signed [DATA_W-1:0] last_value;
  logic                     is_empty;
  logic [4:0]               count;

  // Mirror of the ring, advanced once per accepted beat.
  logic signed [DATA_W-1:0] ring_store [RING_DEPTH];
  logic [3:0]               ring_head = '0;
  logic [4:0]               ring_fill = '0;

  deq_result_t pending_results [$];
  stim_row_t   directed_rows [$];

  // Expectation attached to the beat currently on the command ports.
  logic        beat_typed = 1'b0;
  deq_result_t beat_res;

  int mismatches = 0;
  int gap_mode = 0;

  double_ended_queue DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .push_value   (push_value),
    .done         (done),
    .popped_value (popped_value),
    .ok           (ok),
    .first_value  (first_value),
    .last_value   (last_value),
    .is_empty     (is_empty),
    .count        (count)
  );

  always #4 clk = ~clk;

  // Applies one operation to the mirrored ring and returns what it reports.
  function automatic deq_result_t deque_apply(deq_op_t code, logic signed [DATA_W-1:0] val);
    deq_result_t r;
    logic [3:0]  tail;
    r.popped = EMPTY_MARK;
    r.ok = 1'b0;
    if (code == OP_PUSH_FRONT || code == OP_PUSH_BACK) begin
      if (ring_fill < RING_DEPTH) begin
        if (code == OP_PUSH_FRONT) begin
          ring_head = ring_head - 4'd1;
          ring_store[ring_head] = val;
        end else begin
          ring_store[ring_head + ring_fill[3:0]] = val;
        end
        ring_fill = ring_fill + 5'd1;
        r.ok = 1'b1;
      end
    end else if (ring_fill != 0) begin
      if (code == OP_POP_FRONT) begin
        r.popped = ring_store[ring_head];
        ring_head = ring_head + 4'd1;
      end else begin
        tail = ring_head + ring_fill[3:0] - 4'd1;
        r.popped = ring_store[tail];
      end
      ring_fill = ring_fill - 5'd1;
      r.ok = 1'b1;
    end
    // The front and back are reported after the update.
    tail = ring_head + ring_fill[3:0] - 4'd1;
    r.empty_f = (ring_fill == 0);
    r.first_v = r.empty_f ? EMPTY_MARK : ring_store[ring_head];
    r.last_v  = r.empty_f ? EMPTY_MARK : ring_store[tail];
    r.cnt = ring_fill;
    return r;
  endfunction

  // Compares one field; only the first ten mismatches are printed.
  task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch at %0t: %s expected %h, got %h", $realtime, name, exp_v, act_v);
    end
  endtask

  // Result side: compare each done beat, then record any beat taken at this edge.
  always @(posedge clk) begin
    deq_result_t exp_r;
    deq_result_t pred;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: result beat with nothing expected", $realtime);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("popped_value", exp_r.popped, popped_value);
        check_field("ok", {31'b0, exp_r.ok}, {31'b0, ok});
        check_field("first_value", exp_r.first_v, first_value);
        check_field("last_value", exp_r.last_v, last_value);
        check_field("is_empty", {31'b0, exp_r.empty_f}, {31'b0, is_empty});
        check_field("count", {27'b0, exp_r.cnt}, {27'b0, count});
      end
    end
    if (!rst && start && busy === 1'b0) begin
      pred = deque_apply(deq_op_t'(op), push_value);
      pending_results.push_back(beat_typed ? beat_res : pred);
    end
  end

  // Picks an idle gap: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (gap_mode == 0)
      return 0;
    r = $urandom_range(99);
    if (r < 70)
      return 0;
    if (r < 95)
      return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Drives one command beat and holds it until the block takes it.
  task automatic send_beat(deq_op_t code, logic signed [DATA_W-1:0] val, logic typed,
                           deq_result_t res);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    op = code;
    push_value = val;
    beat_typed = typed;
    beat_res = res;
    forever begin
      @(posedge clk);
      if (busy === 1'b0)
        break;
    end
  endtask

  // Random payload with extra weight on the corner values.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return EMPTY_MARK;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Adds a row to the directed table.
  task automatic add_row(deq_op_t code, logic signed [DATA_W-1:0] val, logic typed,
                         deq_result_t res);
    stim_row_t row;
    row.op = code;
    row.value = val;
    row.typed = typed;
    row.res = res;
    directed_rows.push_back(row);
  endtask

  // Timeout guard.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    deq_result_t none;
    deq_result_t nil_res;
    int          push_pct;
    int          seg_left;
    int          spins;
    deq_op_t     code;

    nil_res = '{popped: '0, ok: 1'b0, first_v: '0, last_v: '0, empty_f: 1'b0, cnt: '0};
    none = '{popped: EMPTY_MARK, ok: 1'b0, first_v: EMPTY_MARK, last_v: EMPTY_MARK,
             empty_f: 1'b1, cnt: 5'd0};
    beat_res = nil_res;

    // Directed table: empty pops, extreme values, a stored -1, then fill to
    // the top with pushes on both ends so the head wraps, and push into full.
    add_row(OP_POP_FRONT, 32'sh1234_5678, 1'b1, none);
    add_row(OP_POP_BACK, '1, 1'b1, none);
    add_row(OP_PUSH_FRONT, 32'sh8000_0000, 1'b1,
            '{EMPTY_MARK, 1'b1, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 5'd1});
    add_row(OP_PUSH_BACK, 32'sh7FFF_FFFF, 1'b1,
            '{EMPTY_MARK, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 5'd2});
    add_row(OP_PUSH_BACK, EMPTY_MARK, 1'b1,
            '{EMPTY_MARK, 1'b1, 32'sh8000_0000, EMPTY_MARK, 1'b0, 5'd3});
    add_row(OP_POP_BACK, '0, 1'b1,
            '{EMPTY_MARK, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 5'd2});
    add_row(OP_POP_FRONT, '0, 1'b1,
            '{32'sh8000_0000, 1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 5'd1});
    for (int i = 0; i < 15; i++)
      add_row(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, i == 0 ? '0 : $urandom, 1'b0, nil_res);
    add_row(OP_PUSH_FRONT, 32'sh5555_5555, 1'b0, nil_res);
    add_row(OP_PUSH_BACK, 32'shAAAA_AAAA, 1'b0, nil_res);
    add_row(OP_POP_BACK, '0, 1'b0, nil_res);

    // Reset is held first, then released away from the sampling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
                directed_rows[i].res);

    // Random part in segments; each picks a push bias and whether to idle.
    seg_left = 0;
    push_pct = 50;
    for (int n = 0; n < RAND_BEATS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(120, 30);
        case ($urandom_range(4))
          0: push_pct = 15;
          1: push_pct = 50;
          2: push_pct = 85;
          3: push_pct = 97;
          default: push_pct = 3;
        endcase
        gap_mode = ($urandom_range(3) != 0);
      end
      seg_left--;
      if ($urandom_range(99) < push_pct)
        code = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else
        code = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
      send_beat(code, pick_value(), 1'b0, nil_res);
    end
    @(negedge clk);
    start = 1'b0;

    // Drain: wait for outstanding results, then a few more cycles.
    spins = 0;
    while (pending_results.size() != 0 && spins < 200) begin
      @(posedge clk);
      spins++;
    end
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatches += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
src/deq_pkg.sv
src/deq_ctrl.sv
src/deq_datapath.sv
src/double_ended_queue.sv
tb/double_ended_queue_tb.sv
